// File: sv/pcca_pkg.sv
// Shared constants for the pixel contrast / color adjust block.
// Field widths, configuration register indexes and the coordinate limit.
// No dependencies.
package pcca_pkg;

  localparam int CHAN_W     = 8;
  localparam int COORD_W    = 12;
  localparam int CONTRAST_W = 12;
  localparam int SHIFT_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // pixels at or beyond this row / column are never processed
  localparam int COORD_LIMIT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd7;

endpackage

// File: sv/pixel_contrast_color_adjust_top.sv
// Brightness / contrast adjustment of ARGB pixels inside a rectangular region.
// Three-stage pixel pipeline plus a bit-serial slope divider for configuration.
// Depends on pcca_pkg.
//
//   channel   handshake                     payload
//   -------   ---------------------------   -----------------------------------------
//   cfg       cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//   in        in_valid_i / in_stall_o       in_red/green/blue/alpha_i, pix_row/col_i
//   out       out_valid_o / out_stall_i     out_red/green/blue/alpha_o
//
// One pixel per cycle unless the output stalls or coefficients are recomputed; the
// stages are region check, multiply, add and clamp; the output register is the third.
// A contrast write holds off requests while the slope is loaded, divided out one
// quotient bit per cycle and the offsets recomputed; a shift write holds them off
// while the per-channel offsets are recomputed.
// Reset leaves the identity setting (slope 1.0, zero offsets) and an empty region.
// A stalled output stage backs up the pipeline one stage at a time; bubbles close up.
module pixel_contrast_color_adjust_top
  import pcca_pkg::*;
#(
  parameter int FRAC_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CHAN_W-1:0]     in_red_i,
  input  logic [CHAN_W-1:0]     in_green_i,
  input  logic [CHAN_W-1:0]     in_blue_i,
  input  logic [CHAN_W-1:0]     in_alpha_i,
  input  logic [COORD_W-1:0]    pix_row_i,
  input  logic [COORD_W-1:0]    pix_col_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAN_W-1:0]     out_red_o,
  output logic [CHAN_W-1:0]     out_green_o,
  output logic [CHAN_W-1:0]     out_blue_o,
  output logic [CHAN_W-1:0]     out_alpha_o
);

  localparam int RW    = FRAC_BITS + 8;   // slope, divisor, remainder
  localparam int QW    = FRAC_BITS + 8;   // quotient bits
  localparam int CNT_W = $clog2(QW);
  localparam int EW    = FRAC_BITS + 9;   // signed contrast math
  localparam int NUMW  = (FRAC_BITS + 16 > 22) ? FRAC_BITS + 16 : 22;
  localparam int ADDW  = NUMW - FRAC_BITS;
  localparam int VW    = ADDW + 1;
  localparam int PW    = RW + CHAN_W;

  localparam logic signed [EW-1:0] ONE_E     = EW'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0] ONE128_E  = EW'(1) << (FRAC_BITS + 7);
  localparam logic [RW-1:0]        ONE_R     = RW'(1) << FRAC_BITS;
  localparam logic [RW-1:0]        REM_INIT  = RW'(1) << (FRAC_BITS - 1);
  localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(QW - 1);
  localparam logic [VW-1:0]        CHAN_MAX  = VW'(255);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_ADD  = 2'd3;

  // integer offset: trunc toward zero of ((ONE - slope)*128 + shift*255) / ONE
  function automatic logic signed [ADDW-1:0] calc_add(input logic [RW-1:0] sl,
                                                       input logic signed [SHIFT_W-1:0] sh);
    logic signed [NUMW-1:0] one_n;
    logic signed [NUMW-1:0] sx;
    logic signed [NUMW-1:0] sum;
    one_n = NUMW'(1) << FRAC_BITS;
    sx    = NUMW'(sh);
    sum   = ((one_n - NUMW'(sl)) <<< 7) + ((sx <<< 8) - sx);
    if (sum < 0) begin
      sum = sum + (one_n - NUMW'(1));
    end
    return sum[NUMW-1:FRAC_BITS];
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [CONTRAST_W-1:0] contrast_q;
  logic signed [SHIFT_W-1:0]    red_shift_q, green_shift_q, blue_shift_q;
  logic [COORD_W-1:0]           left_q, right_q, top_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q    <= '0;
      red_shift_q   <= '0;
      green_shift_q <= '0;
      blue_shift_q  <= '0;
      left_q        <= '0;
      right_q       <= '0;
      top_q         <= '0;
      bottom_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CONTRAST:      contrast_q    <= cfg_wdata_i[CONTRAST_W-1:0];
        REG_RED_SHIFT:     red_shift_q   <= cfg_wdata_i[SHIFT_W-1:0];
        REG_GREEN_SHIFT:   green_shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        REG_BLUE_SHIFT:    blue_shift_q  <= cfg_wdata_i[SHIFT_W-1:0];
        REG_REGION_LEFT:   left_q        <= cfg_wdata_i[COORD_W-1:0];
        REG_REGION_RIGHT:  right_q       <= cfg_wdata_i[COORD_W-1:0];
        REG_REGION_TOP:    top_q         <= cfg_wdata_i[COORD_W-1:0];
        REG_REGION_BOTTOM: bottom_q      <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------- slope / offset sequencer
  logic signed [EW-1:0] kx, kc, kmul, d_e, n_e;
  logic                 k_pos;
  logic [RW-1:0]        slope_neg;

  always_comb begin
    kx = EW'(contrast_q);
    if (kx > ONE_E) begin
      kc = ONE_E;
    end else if (kx < -ONE_E) begin
      kc = -ONE_E;
    end else begin
      kc = kx;
    end
    kmul      = (kc <<< 7) - kc;
    d_e       = ONE128_E - kmul;
    n_e       = ONE128_E + kmul;
    k_pos     = !kc[EW-1];
    slope_neg = RW'(n_e[EW-1:7]);
  end

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [RW-1:0]           rem_q, rem_d, dvs_q, dvs_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic [RW-1:0]           slope_q, slope_d;
  logic signed [ADDW-1:0]  add_r_q, add_g_q, add_b_q;
  logic signed [ADDW-1:0]  add_r_d, add_g_d, add_b_d;
  logic [RW:0]             trial, trial_sub;
  logic                    trial_ge;
  logic                    wr_contrast, wr_shift;

  assign wr_contrast = cfg_we_i && (cfg_idx_i == REG_CONTRAST);
  assign wr_shift    = cfg_we_i && ((cfg_idx_i == REG_RED_SHIFT) ||
                                    (cfg_idx_i == REG_GREEN_SHIFT) ||
                                    (cfg_idx_i == REG_BLUE_SHIFT));

  assign trial     = {rem_q, 1'b0};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign trial_ge  = trial >= {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    slope_d = slope_q;
    add_r_d = add_r_q;
    add_g_d = add_g_q;
    add_b_d = add_b_q;
    unique case (state_q)
      ST_LOAD: begin
        dvs_d   = d_e[RW-1:0];
        rem_d   = REM_INIT;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
        quo_d = {quo_q[QW-2:0], trial_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          slope_d = k_pos ? quo_d : slope_neg;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        add_r_d = calc_add(slope_q, red_shift_q);
        add_g_d = calc_add(slope_q, green_shift_q);
        add_b_d = calc_add(slope_q, blue_shift_q);
        state_d = ST_IDLE;
      end
      default: ;
    endcase
    // a new write restarts whatever part of the sequence it affects
    priority if (wr_contrast) begin
      state_d = ST_LOAD;
    end else if (wr_shift && (state_q == ST_IDLE || state_q == ST_ADD)) begin
      state_d = ST_ADD;
    end else begin
      state_d = state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      slope_q <= ONE_R;
      add_r_q <= '0;
      add_g_q <= '0;
      add_b_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      slope_q <= slope_d;
      add_r_q <= add_r_d;
      add_g_q <= add_g_d;
      add_b_q <= add_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  // ---------------------------------------------------------------- pipeline
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3, in_acc, in_region;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = (state_q != ST_IDLE) || !en1;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_region = (32'(pix_row_i) < COORD_LIMIT) && (32'(pix_col_i) < COORD_LIMIT) &&
                     (pix_row_i >= top_q) && (pix_row_i < bottom_q) &&
                     (pix_col_i >= left_q) && (pix_col_i < right_q);

  // stage 1: region check
  logic [CHAN_W-1:0] r1_q, g1_q, b1_q, a1_q;
  logic              in1_q;
  // stage 2: slope products
  logic [CHAN_W-1:0] r2_q, g2_q, b2_q, a2_q;
  logic              in2_q;
  logic [PW-1:0]     pr2_q, pg2_q, pb2_q;
  // stage 3: output register
  logic [CHAN_W-1:0] r3_q, g3_q, b3_q, a3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_acc;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  function automatic logic [CHAN_W-1:0] finish(input logic [PW-1:0] prod,
                                               input logic signed [ADDW-1:0] ofs);
    logic signed [VW-1:0] v;
    v = signed'(VW'(prod[PW-1:FRAC_BITS])) + VW'(ofs);
    if (v < 0) begin
      return '0;
    end else if (v > signed'(CHAN_MAX)) begin
      return '1;
    end
    return v[CHAN_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q  <= in_red_i;
      g1_q  <= in_green_i;
      b1_q  <= in_blue_i;
      a1_q  <= in_alpha_i;
      in1_q <= in_region;
    end
    if (en2) begin
      r2_q  <= r1_q;
      g2_q  <= g1_q;
      b2_q  <= b1_q;
      a2_q  <= a1_q;
      in2_q <= in1_q;
      pr2_q <= PW'(slope_q) * PW'(r1_q);
      pg2_q <= PW'(slope_q) * PW'(g1_q);
      pb2_q <= PW'(slope_q) * PW'(b1_q);
    end
    if (en3) begin
      r3_q <= in2_q ? finish(pr2_q, add_r_q) : r2_q;
      g3_q <= in2_q ? finish(pg2_q, add_g_q) : g2_q;
      b3_q <= in2_q ? finish(pb2_q, add_b_q) : b2_q;
      a3_q <= a2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_red_o   = r3_q;
  assign out_green_o = g3_q;
  assign out_blue_o  = b3_q;
  assign out_alpha_o = a3_q;

endmodule

// File: sv/pcca_checker.sv
// Port-level checks for pixel_contrast_color_adjust_top, attached by bind.
// Depends on pcca_pkg.
module pcca_assert
  import pcca_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [CHAN_W-1:0]     in_red_i,
  input logic [CHAN_W-1:0]     in_green_i,
  input logic [CHAN_W-1:0]     in_blue_i,
  input logic [CHAN_W-1:0]     in_alpha_i,
  input logic [COORD_W-1:0]    pix_row_i,
  input logic [COORD_W-1:0]    pix_col_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [CHAN_W-1:0]     out_red_o,
  input logic [CHAN_W-1:0]     out_green_o,
  input logic [CHAN_W-1:0]     out_blue_o,
  input logic [CHAN_W-1:0]     out_alpha_o
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a slope or offset change must hold off requests while it is recomputed
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_CONTRAST || cfg_idx_i == REG_RED_SHIFT ||
                  cfg_idx_i == REG_GREEN_SHIFT || cfg_idx_i == REG_BLUE_SHIFT))
    |=> in_stall_o)
    else $error("request accepted while coefficients update");

  // a stalled request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(in_red_i) && $stable(in_green_i) && $stable(in_blue_i) &&
       $stable(in_alpha_i) && $stable(pix_row_i) && $stable(pix_col_i)))
    else $error("stalled request changed");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_red_o) && $stable(out_green_o) &&
       $stable(out_blue_o) && $stable(out_alpha_o)))
    else $error("stalled result changed");

endmodule

bind pixel_contrast_color_adjust_top pcca_assert u_pcca_assert (.*);

// File: tb/pcca_checker.sv
// Checker for the pixel contrast / color adjust block: tracks register writes,
// predicts each accepted request's adjusted pixel and compares it with the outputs.
// Depends on pcca_pkg.
module pcca_checker
  import pcca_pkg::*;
#(
  parameter int FRAC_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CHAN_W-1:0]     in_red_i,
  input  logic [CHAN_W-1:0]     in_green_i,
  input  logic [CHAN_W-1:0]     in_blue_i,
  input  logic [CHAN_W-1:0]     in_alpha_i,
  input  logic [COORD_W-1:0]    pix_row_i,
  input  logic [COORD_W-1:0]    pix_col_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CHAN_W-1:0]     out_red_i,
  input  logic [CHAN_W-1:0]     out_green_i,
  input  logic [CHAN_W-1:0]     out_blue_i,
  input  logic [CHAN_W-1:0]     out_alpha_i,
  output int                    mismatch_cnt_o,
  output int                    in_flight_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNITY = longint'(1) << FRAC_BITS;

  // index 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][CHAN_W-1:0] argb_t;

  logic signed [CONTRAST_W-1:0] contrast_q    = '0;
  logic signed [SHIFT_W-1:0]    red_shift_q   = '0;
  logic signed [SHIFT_W-1:0]    green_shift_q = '0;
  logic signed [SHIFT_W-1:0]    blue_shift_q  = '0;
  logic [COORD_W-1:0]           left_q        = '0;
  logic [COORD_W-1:0]           right_q       = '0;
  logic [COORD_W-1:0]           top_q         = '0;
  logic [COORD_W-1:0]           bottom_q      = '0;

  argb_t expected_pixels[$];

  function automatic string chan_label(int ch);
    case (ch)
      0:       return "red";
      1:       return "green";
      2:       return "blue";
      default: return "alpha";
    endcase
  endfunction

  // Q.F gain; contrast beyond +-1.0 is saturated first
  function automatic longint gain_from_contrast(longint k_raw);
    longint k;
    k = k_raw;
    if (k > UNITY) k = UNITY;
    if (k < -UNITY) k = -UNITY;
    if (k >= 0) return (128 * UNITY * UNITY) / (128 * UNITY - 127 * k);
    return (128 * UNITY + 127 * k) / 128;
  endfunction

  function automatic logic [CHAN_W-1:0] tone_map(logic [CHAN_W-1:0] c, longint gain,
                                                 longint shift);
    longint offs;
    longint v;
    // SV division truncates toward zero
    offs = ((UNITY - gain) * 128 + shift * 255) / UNITY;
    v = ((gain * longint'(c)) >>> FRAC_BITS) + offs;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic argb_t predict_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                          logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a,
                                          logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    argb_t px;
    longint gain;
    px = {a, b, g, r};
    if (row < COORD_LIMIT && col < COORD_LIMIT && row >= top_q && row < bottom_q &&
        col >= left_q && col < right_q) begin
      gain = gain_from_contrast(contrast_q);
      px[0] = tone_map(r, gain, red_shift_q);
      px[1] = tone_map(g, gain, green_shift_q);
      px[2] = tone_map(b, gain, blue_shift_q);
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    argb_t got;
    argb_t want;
    if (!rst_ni) begin
      contrast_q    = '0;
      red_shift_q   = '0;
      green_shift_q = '0;
      blue_shift_q  = '0;
      left_q        = '0;
      right_q       = '0;
      top_q         = '0;
      bottom_q      = '0;
      expected_pixels.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {out_alpha_i, out_blue_i, out_green_i, out_red_i};
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with nothing expected: r=%0d g=%0d b=%0d a=%0d",
                   $time, got[0], got[1], got[2], got[3]);
          mismatch_cnt_o++;
        end else begin
          want = expected_pixels.pop_front();
          for (int ch = 0; ch < 4; ch++) begin
            if (got[ch] !== want[ch]) begin
              $display("%0t: %s expected %0d actual %0d", $time, chan_label(ch),
                       want[ch], got[ch]);
              mismatch_cnt_o++;
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_pixels.push_back(predict_pixel(in_red_i, in_green_i, in_blue_i,
                                                in_alpha_i, pix_row_i, pix_col_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CONTRAST:      contrast_q    = cfg_wdata_i[CONTRAST_W-1:0];
          REG_RED_SHIFT:     red_shift_q   = cfg_wdata_i[SHIFT_W-1:0];
          REG_GREEN_SHIFT:   green_shift_q = cfg_wdata_i[SHIFT_W-1:0];
          REG_BLUE_SHIFT:    blue_shift_q  = cfg_wdata_i[SHIFT_W-1:0];
          REG_REGION_LEFT:   left_q        = cfg_wdata_i[COORD_W-1:0];
          REG_REGION_RIGHT:  right_q       = cfg_wdata_i[COORD_W-1:0];
          REG_REGION_TOP:    top_q         = cfg_wdata_i[COORD_W-1:0];
          REG_REGION_BOTTOM: bottom_q      = cfg_wdata_i[COORD_W-1:0];
          default: ;
        endcase
      end
    end
    in_flight_o = expected_pixels.size();
  end

endmodule

// File: tb/tb_pixel_contrast_color_adjust_top.sv
// Testbench top for pixel_contrast_color_adjust_top: drives register settings and
// pixel requests with random idling on both channels; pcca_checker does the checking.
// Depends on pcca_pkg, pcca_checker and the block itself.
module tb_pixel_contrast_color_adjust_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcca_pkg::*;

  localparam int PIPE_DEPTH = 3;
  localparam int COORD_MAX  = 4095;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [CHAN_W-1:0]     in_red_i    = '0;
  logic [CHAN_W-1:0]     in_green_i  = '0;
  logic [CHAN_W-1:0]     in_blue_i   = '0;
  logic [CHAN_W-1:0]     in_alpha_i  = '0;
  logic [COORD_W-1:0]    pix_row_i   = '0;
  logic [COORD_W-1:0]    pix_col_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CHAN_W-1:0]     out_red_o;
  logic [CHAN_W-1:0]     out_green_o;
  logic [CHAN_W-1:0]     out_blue_o;
  logic [CHAN_W-1:0]     out_alpha_o;

  int mismatch_cnt;
  int in_flight;
  int send_gap_pct = 37;
  int stall_pct    = 85;

  // region as last written, used to aim coordinates at the edges
  int cur_left, cur_right, cur_top, cur_bottom;

  pixel_contrast_color_adjust_top #(.FRAC_BITS(10)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_red_i, .in_green_i, .in_blue_i, .in_alpha_i,
    .pix_row_i, .pix_col_i,
    .out_valid_o, .out_stall_i, .out_red_o, .out_green_o, .out_blue_o, .out_alpha_o
  );

  pcca_checker #(.FRAC_BITS(10)) i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_red_i, .in_green_i, .in_blue_i,
    .in_alpha_i, .pix_row_i, .pix_col_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_red_i(out_red_o),
    .out_green_i(out_green_o), .out_blue_i(out_blue_o), .out_alpha_i(out_alpha_o),
    .mismatch_cnt_o(mismatch_cnt), .in_flight_o(in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a,
                            logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    bit stalled;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    in_alpha_i <= a;
    pix_row_i  <= row;
    pix_col_i  <= col;
    // stall sampled mid-cycle, request taken at the following edge if clear
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // drop valid and wait for every outstanding pixel to come out
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (in_flight != 0);
    repeat (PIPE_DEPTH + 3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_setting(logic [CFG_DATA_W-1:0] k, logic [CFG_DATA_W-1:0] sr,
                              logic [CFG_DATA_W-1:0] sg, logic [CFG_DATA_W-1:0] sb,
                              logic [CFG_DATA_W-1:0] l, logic [CFG_DATA_W-1:0] r,
                              logic [CFG_DATA_W-1:0] t, logic [CFG_DATA_W-1:0] b);
    write_reg(REG_RED_SHIFT, sr);
    write_reg(REG_GREEN_SHIFT, sg);
    write_reg(REG_BLUE_SHIFT, sb);
    write_reg(REG_REGION_LEFT, l);
    write_reg(REG_REGION_RIGHT, r);
    write_reg(REG_REGION_TOP, t);
    write_reg(REG_REGION_BOTTOM, b);
    // contrast last so the offsets computed after the slope divide use the final shifts
    write_reg(REG_CONTRAST, k);
    cur_left   = int'(l[COORD_W-1:0]);
    cur_right  = int'(r[COORD_W-1:0]);
    cur_top    = int'(t[COORD_W-1:0]);
    cur_bottom = int'(b[COORD_W-1:0]);
  endtask

  // mostly within +-span, with the ends, zero and raw 13-bit patterns mixed in
  function automatic logic [CFG_DATA_W-1:0] pick_signed(int span);
    case ($urandom_range(9))
      0:       return CFG_DATA_W'(-span);
      1:       return CFG_DATA_W'(span);
      2:       return CFG_DATA_W'($urandom);
      3:       return '0;
      default: return CFG_DATA_W'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  task automatic pick_span(output int lo, output int hi);
    int a0, a1;
    a0 = $urandom_range(COORD_MAX);
    a1 = $urandom_range(COORD_MAX);
    case ($urandom_range(9))
      0: begin  // empty
        lo = (a0 > a1) ? a0 : a1;
        hi = (a0 > a1) ? a1 : a0;
      end
      1: begin
        lo = 0;
        hi = COORD_MAX;
      end
      default: begin
        lo = (a0 < a1) ? a0 : a1;
        hi = (a0 < a1) ? a1 : a0;
      end
    endcase
  endtask

  task automatic random_setting();
    int l, r, t, b;
    pick_span(l, r);
    pick_span(t, b);
    load_setting(pick_signed(1024), pick_signed(2048), pick_signed(2048), pick_signed(2048),
                 {1'($urandom_range(1)), COORD_W'(l)}, {1'($urandom_range(1)), COORD_W'(r)},
                 {1'($urandom_range(1)), COORD_W'(t)}, {1'($urandom_range(1)), COORD_W'(b)});
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(int lo, int hi);
    int sel;
    sel = $urandom_range(99);
    if (sel < 70 && lo < hi) return COORD_W'($urandom_range(hi - 1, lo));
    if (sel < 88) begin
      case ($urandom_range(3))
        0:       return COORD_W'(lo - 1);
        1:       return COORD_W'(lo);
        2:       return COORD_W'(hi - 1);
        default: return COORD_W'(hi);
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0:       return 8'd0;
        1:       return 8'd255;
        2:       return 8'd127;
        default: return 8'd128;
      endcase
    end
    return CHAN_W'($urandom);
  endfunction

  task automatic send_random_pixel();
    send_pixel(pick_chan(), pick_chan(), pick_chan(), CHAN_W'($urandom),
               pick_coord(cur_top, cur_bottom), pick_coord(cur_left, cur_right));
  endtask

  initial begin
    int pause_at;
    cur_left   = 0;
    cur_right  = 0;
    cur_top    = 0;
    cur_bottom = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: empty region, everything passes through
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);

    // full contrast in a small window; coordinates on each edge
    settle();
    load_setting(13'd1024, 13'd0, 13'd0, 13'd0, 13'd10, 13'd20, 13'd5, 13'd9);
    send_pixel(8'd0, 8'd255, 8'd128, 8'd0, 12'd5, 12'd10);
    send_pixel(8'd127, 8'd128, 8'd129, 8'd255, 12'd8, 12'd19);
    send_pixel(8'd200, 8'd50, 8'd128, 8'd7, 12'd9, 12'd10);
    send_pixel(8'd200, 8'd50, 8'd128, 8'd7, 12'd4, 12'd10);
    send_pixel(8'd200, 8'd50, 8'd128, 8'd7, 12'd5, 12'd9);
    send_pixel(8'd200, 8'd50, 8'd128, 8'd7, 12'd5, 12'd20);

    // contrast below -1.0 saturates; extreme shifts clamp high and low
    settle();
    load_setting(-13'sd2048, 13'd4095, 13'h1000, 13'd0, 13'd0, 13'd4095, 13'd0, 13'd4095);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd1, 12'd0, 12'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd254, 12'd4094, 12'd4094);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd128, 12'd4095, 12'd0);

    // contrast above +1.0 saturates; left past right leaves no region
    settle();
    load_setting(13'd2047, -13'sd2048, 13'd2048, 13'd100, 13'd100, 13'd50, 13'd0, 13'd4095);
    send_pixel(8'd10, 8'd20, 8'd30, 8'd40, 12'd70, 12'd70);
    send_pixel(8'd250, 8'd5, 8'd128, 8'd99, 12'd200, 12'd100);

    // top equal to bottom: empty again
    settle();
    load_setting(-13'sd1024, 13'd1, 13'd2048, -13'sd1, 13'd0, 13'd4095, 13'd7, 13'd7);
    send_pixel(8'd90, 8'd91, 8'd92, 8'd93, 12'd7, 12'd7);

    // small contrast magnitudes
    settle();
    load_setting(-13'sd1, 13'd300, -13'sd300, 13'd0, 13'd0, 13'd4095, 13'd0, 13'd4095);
    send_pixel(8'd100, 8'd0, 8'd255, 8'd3, 12'd2048, 12'd1024);
    settle();
    load_setting(13'd1, 13'd0, 13'd0, 13'd0, 13'd0, 13'd4095, 13'd0, 13'd4095);
    send_pixel(8'd100, 8'd200, 8'd255, 8'd3, 12'd1, 12'd4094);

    for (int mode = 0; mode < 3; mode++) begin
      settle();
      case (mode)
        0: begin send_gap_pct = 37; stall_pct <= 85; end
        1: begin send_gap_pct = 85; stall_pct <= 37; end
        default: begin send_gap_pct = 0; stall_pct <= 0; end
      endcase
      repeat (4) begin
        settle();
        random_setting();
        pause_at = $urandom_range(74);
        for (int n = 0; n < 75; n++) begin
          if (n == pause_at) settle();
          send_random_pixel();
        end
      end
    end

    settle();
    @(negedge clk_i);
    if (mismatch_cnt == 0 && in_flight == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: pixel_contrast_color_adjust_top.f
sv/pcca_pkg.sv
sv/pixel_contrast_color_adjust_top.sv
sv/pcca_checker.sv
tb/pcca_checker.sv
tb/tb_pixel_contrast_color_adjust_top.sv
